[rtl/smme_pkg.sv]
// Shared types, constants and helper functions for the stereo mix mu-law encoder.
// No dependencies; every other file in rtl/ imports this package.
package smme_pkg;

    // Field widths
    localparam int SampleW = 16;
    localparam int CodeW   = 8;
    localparam int PctW    = 7;
    localparam int WeightW = 9;   // mix weight 0..256
    localparam int MixW    = 16;  // mixed channel value, signed
    localparam int CfgIdxW = 2;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_STEREO_MODE = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_MIX_PERCENT = 2'd1;

    // Mixer constants
    localparam logic [PctW-1:0]    PCT_MAX     = 7'd100;
    localparam logic [WeightW:0]   WEIGHT_FULL = 10'd512;
    // floor(x / 25) = (x * 5243) >> 17 for x < 6401
    localparam logic [25:0]        RECIP_25    = 26'd5243;

    // Encoder constants
    localparam logic [15:0] MAG_CLIP   = 16'd8160;
    localparam logic [CodeW-1:0] CODE_CLIP = 8'h80;
    localparam logic [12:0] SEG_BASE [8] = '{
        13'd0, 13'd32, 13'd96, 13'd224, 13'd480, 13'd992, 13'd2016, 13'd4064
    };

    // Input word
    typedef struct packed {
        logic signed [SampleW-1:0] left_sample;
        logic signed [SampleW-1:0] right_sample;
    } in_word_t;

    // Output word
    typedef struct packed {
        logic [CodeW-1:0] left_code;
        logic [CodeW-1:0] right_code;
        logic             right_valid;
    } out_word_t;

    // Configuration seen by the mixer
    typedef struct packed {
        logic               stereo_mode;
        logic [WeightW-1:0] weight;
    } mix_cfg_t;

    // Mixed channel pair between mixer and encoders
    typedef struct packed {
        logic signed [MixW-1:0] left_mix;
        logic signed [MixW-1:0] right_mix;
        logic                   right_valid;
    } mix_word_t;

    // weight = min(pct,100) * 256 / 100 = (min(pct,100) * 64) / 25
    function automatic logic [WeightW-1:0] pct_to_weight(input logic [PctW-1:0] pct);
        logic [PctW-1:0] pct_c;
        logic [25:0]     scaled;
        logic [25:0]     prod;
        pct_c  = (pct > PCT_MAX) ? PCT_MAX : pct;
        scaled = {13'd0, pct_c, 6'd0};
        prod   = scaled * RECIP_25;
        return prod[17+WeightW-1:17];
    endfunction

endpackage

[rtl/smme_cfg.sv]
// Configuration registers: stereo mode and cross-mix weight.
// Depends on smme_pkg.
module smme_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [smme_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [smme_pkg::PctW-1:0]       cfg_data,
    output smme_pkg::mix_cfg_t              mix_cfg
);
    import smme_pkg::*;

    logic               stereo_reg, stereo_next;
    logic [WeightW-1:0] weight_reg, weight_next;

    // Writes are always taken
    assign cfg_ready = 1'b1;

    // Decode the register index; the percent is turned into a weight on write
    always_comb
    begin
        stereo_next = stereo_reg;
        weight_next = weight_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_STEREO_MODE: stereo_next = cfg_data[0];
                CFG_MIX_PERCENT: weight_next = pct_to_weight(cfg_data);
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stereo_reg <= 1'b0;
            weight_reg <= '0;
        end
        else
        begin
            stereo_reg <= stereo_next;
            weight_reg <= weight_next;
        end
    end

    assign mix_cfg.stereo_mode = stereo_reg;
    assign mix_cfg.weight      = weight_reg;

endmodule

[rtl/smme_mixer.sv]
// Channel mixer: stereo cross-mix, plain stereo scaling, or mono sum.
// Depends on smme_pkg.
module smme_mixer (
    input  smme_pkg::in_word_t  in_word,
    input  smme_pkg::mix_cfg_t  mix_cfg,
    output smme_pkg::mix_word_t mix_word
);
    import smme_pkg::*;

    logic signed [25:0]      l_ext, r_ext;
    logic signed [25:0]      p_ext, q_ext;
    logic        [WeightW:0] q_u;
    logic signed [25:0]      sum_l, sum_r;
    logic signed [16:0]      mono_sum;

    // Weights: own channel p, other channel 512 - p
    assign q_u   = WEIGHT_FULL - {1'b0, mix_cfg.weight};
    assign p_ext = $signed({17'd0, mix_cfg.weight});
    assign q_ext = $signed({16'd0, q_u});
    assign l_ext = 26'(in_word.left_sample);
    assign r_ext = 26'(in_word.right_sample);

    // Cross-mix products; the sum fits in 26 bits since p + q = 512
    assign sum_l = l_ext * p_ext + r_ext * q_ext;
    assign sum_r = r_ext * p_ext + l_ext * q_ext;

    assign mono_sum = 17'(in_word.left_sample) + 17'(in_word.right_sample);

    // Select by mode; arithmetic shifts are taken as upper bit slices
    always_comb
    begin
        if (mix_cfg.stereo_mode)
        begin
            mix_word.right_valid = 1'b1;
            if (mix_cfg.weight != '0)
            begin
                mix_word.left_mix  = sum_l[25:10];
                mix_word.right_mix = sum_r[25:10];
            end
            else
            begin
                mix_word.left_mix  = {{2{in_word.left_sample[15]}}, in_word.left_sample[15:2]};
                mix_word.right_mix = {{2{in_word.right_sample[15]}},
                                      in_word.right_sample[15:2]};
            end
        end
        else
        begin
            mix_word.right_valid = 1'b0;
            mix_word.left_mix    = {mono_sum[16], mono_sum[16:2]};
            mix_word.right_mix   = '0;
        end
    end

endmodule

[rtl/smme_encoder.sv]
// Mu-law encoder for one channel: eight segments, saturation at 8160.
// Depends on smme_pkg.
module smme_encoder (
    input  logic signed [smme_pkg::MixW-1:0] value,
    output logic        [smme_pkg::CodeW-1:0] code
);
    import smme_pkg::*;

    logic        neg;
    logic [15:0] mag;
    logic [2:0]  seg;
    logic [12:0] offset;
    logic [12:0] shifted;
    logic [3:0]  step;
    logic [7:0]  raw_code;

    // Magnitude and sign
    assign neg = value[MixW-1];
    assign mag = neg ? 16'(-value) : 16'(value);

    // Segment search, highest base first
    always_comb
    begin
        if (mag >= {3'd0, SEG_BASE[7]})
            seg = 3'd7;
        else if (mag >= {3'd0, SEG_BASE[6]})
            seg = 3'd6;
        else if (mag >= {3'd0, SEG_BASE[5]})
            seg = 3'd5;
        else if (mag >= {3'd0, SEG_BASE[4]})
            seg = 3'd4;
        else if (mag >= {3'd0, SEG_BASE[3]})
            seg = 3'd3;
        else if (mag >= {3'd0, SEG_BASE[2]})
            seg = 3'd2;
        else if (mag >= {3'd0, SEG_BASE[1]})
            seg = 3'd1;
        else
            seg = 3'd0;
    end

    // Step within the segment; step size is 2^(seg+1)
    assign offset   = mag[12:0] - SEG_BASE[seg];
    assign shifted  = offset >> ({1'b0, seg} + 4'd1);
    assign step     = shifted[3:0];
    assign raw_code = {1'b1, ~seg, ~step};

    // Sign mask clears bit 7 for negative values; clip above range
    always_comb
    begin
        if (mag >= MAG_CLIP)
            code = neg ? 8'h00 : CODE_CLIP;
        else
            code = neg ? {1'b0, raw_code[6:0]} : raw_code;
    end

endmodule

[rtl/stereo_mix_mulaw_encoder_top.sv]
// Stereo mix mu-law encoder top level: handshake pipeline around mixer and encoders.
// Depends on smme_pkg, smme_cfg, smme_mixer and smme_encoder.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one stereo sample pair per
//   word. Output channel (out_valid/out_ready/out_data) gives one word of mu-law
//   codes per input word, in order. Configuration channel (cfg_valid/cfg_ready,
//   cfg_index, cfg_data) writes stereo_mode (index 0) and mix_percent (index 1);
//   writes are always taken and must be done while no word is in flight.
//   Pipeline: input register, mix register, output register. A word accepted into
//   the input register moves through the mix register to the output register.
//   One word is accepted every cycle while the output is taken; each stage loads
//   when it is empty or its word moves on, so stages advance independently.
//   When out_ready is low the pipeline fills; in_ready falls only once all three
//   stages hold a word, and every held word keeps its value.
//   Reset clears the stage valid flags and sets stereo_mode and mix_percent
//   to 0 (mono mode, no cross-mix).
module stereo_mix_mulaw_encoder_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  smme_pkg::in_word_t            in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output smme_pkg::out_word_t           out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [smme_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [smme_pkg::PctW-1:0]     cfg_data
);
    import smme_pkg::*;

    mix_cfg_t  mix_cfg;
    in_word_t  in_reg;
    mix_word_t mix_comb, mix_reg;
    out_word_t out_comb, out_reg;
    logic      in_vld_reg, mix_vld_reg, out_vld_reg;
    logic      adv_in, adv_mix, adv_out;

    // Configuration registers
    smme_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mix_cfg   (mix_cfg)
    );

    // Stage advance: a stage loads when it is empty or its word moves on
    assign adv_out  = !out_vld_reg || out_ready;
    assign adv_mix  = !mix_vld_reg || adv_out;
    assign adv_in   = !in_vld_reg  || adv_mix;
    assign in_ready = adv_in;

    // Mixer between input and mix registers
    smme_mixer u_mixer (
        .in_word  (in_reg),
        .mix_cfg  (mix_cfg),
        .mix_word (mix_comb)
    );

    // Encoders between mix and output registers
    smme_encoder u_enc_left (
        .value (mix_reg.left_mix),
        .code  (out_comb.left_code)
    );

    smme_encoder u_enc_right (
        .value (mix_reg.right_mix),
        .code  (out_comb.right_code)
    );

    assign out_comb.right_valid = mix_reg.right_valid;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            mix_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (adv_in)
                in_vld_reg <= in_valid;
            if (adv_mix)
                mix_vld_reg <= in_vld_reg;
            if (adv_out)
                out_vld_reg <= mix_vld_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv_in)
            in_reg <= in_data;
        if (adv_mix)
            mix_reg <= mix_comb;
        if (adv_out)
        begin
            out_reg.left_code   <= out_comb.left_code;
            out_reg.right_code  <= mix_reg.right_valid ? out_comb.right_code : '0;
            out_reg.right_valid <= out_comb.right_valid;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

endmodule
